// File: src/polar_cartesian_converter_defines.svh
// Assertion macros shared by the polar/cartesian converter RTL.
`ifndef POLAR_CARTESIAN_CONVERTER_DEFINES_SVH
`define POLAR_CARTESIAN_CONVERTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/pcc_pkg.sv
// Types, angle constants and CORDIC tables for the polar/cartesian converter.
package pcc_pkg;

  localparam int unsigned GUARD = 24;
  localparam int unsigned VEC_W = 58;
  localparam int unsigned ANG_W = 32;
  localparam int unsigned K_W   = 30;

  localparam logic signed [31:0] ANG_PI       = 32'sd843314857;
  localparam logic signed [31:0] ANG_HALF_PI  = 32'sd421657428;
  localparam logic signed [31:0] ANG_3HALF_PI = 32'sd1264972285;
  localparam logic signed [31:0] ANG_2PI      = 32'sd1686629713;
  localparam logic signed [31:0] ANG_2PI_M1   = 32'sd1686629712;
  localparam logic signed [31:0] LEN_MAX      = 32'sh7fff_ffff;

  typedef enum logic {
    OP_P2C = 1'b0,
    OP_C2P = 1'b1
  } pcc_op_e;

  typedef struct packed {
    pcc_op_e            op;
    logic signed [31:0] coord_a;
    logic signed [31:0] coord_b;
  } pcc_in_t;

  typedef struct packed {
    logic signed [31:0] result_a;
    logic signed [31:0] result_b;
    logic               range_error;
  } pcc_out_t;

  // Control that travels alongside the vector through the pipe.
  typedef struct packed {
    logic     vld;
    pcc_op_e  op;
    logic     frc;      // result already known, datapath ignored
    pcc_out_t frc_res;
    logic     xneg;
    logic     yneg;
  } pcc_ctl_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ANG_W-1:0] z;
  } pcc_vec_t;

  // round(atan(2^-i) * 2^28)
  function automatic logic signed [31:0] atan_lut(int unsigned idx);
    logic signed [31:0] v;
    case (idx)
      0:  v = 32'sd210828714;
      1:  v = 32'sd124459457;
      2:  v = 32'sd65760959;
      3:  v = 32'sd33381290;
      4:  v = 32'sd16755422;
      5:  v = 32'sd8385879;
      6:  v = 32'sd4193963;
      7:  v = 32'sd2097109;
      8:  v = 32'sd1048571;
      9:  v = 32'sd524287;
      10: v = 32'sd262144;
      11: v = 32'sd131072;
      12: v = 32'sd65536;
      13: v = 32'sd32768;
      14: v = 32'sd16384;
      15: v = 32'sd8192;
      16: v = 32'sd4096;
      17: v = 32'sd2048;
      18: v = 32'sd1024;
      19: v = 32'sd512;
      20: v = 32'sd256;
      21: v = 32'sd128;
      22: v = 32'sd64;
      23: v = 32'sd32;
      24: v = 32'sd16;
      25: v = 32'sd8;
      26: v = 32'sd4;
      27: v = 32'sd2;
      28: v = 32'sd1;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

  // CORDIC gain in Q30 for a given number of micro-rotations
  function automatic logic [K_W-1:0] gain_q30(int unsigned steps);
    int unsigned n;
    logic [63:0] tail;
    n = steps;
    if (n < 1) n = 1;
    if (n > 30) n = 30;
    tail = (64'd434688583 + (64'd1 << (2 * n - 1))) >> (2 * n);
    return K_W'(64'd652032874 + tail);
  endfunction

endpackage

// File: src/polar_cartesian_converter.sv
// Top level of the pipelined CORDIC polar/cartesian converter.
// Usage:
//   A transaction is offered on cmd_i with start_i high; it is taken at the
//   rising edge where start_i is high and busy_o is low. busy_o never rises,
//   so one transaction can be taken every cycle.
//   op = OP_P2C turns (r, theta) into (x, y); op = OP_C2P turns (x, y) into
//   (r, theta) with theta in [0, 2pi). Lengths Q16.16, angles Q4.28 radians.
//   Each result appears on result_o for one cycle with done_o high, after its
//   transaction has passed two front-end stages, one register per
//   micro-rotation and two back-end stages. Results leave in order of
//   arrival.
//   There is no back-pressure on the result side; the receiver must take
//   every result in the cycle it is shown.
//   Reset clears all valid bits; transactions in flight are dropped and no
//   result is shown until new transactions arrive.
`include "polar_cartesian_converter_defines.svh"

module polar_cartesian_converter #(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  pcc_pkg::pcc_in_t  cmd_i,
  output logic              done_o,
  output pcc_pkg::pcc_out_t result_o
);

  localparam int unsigned LAT = CORDIC_STEPS + 4;

  pcc_pkg::pcc_ctl_t ctl_s [CORDIC_STEPS+1];
  pcc_pkg::pcc_vec_t vec_s [CORDIC_STEPS+1];

  assign busy_o = 1'b0;

  pcc_pre #(
    .STEPS (CORDIC_STEPS)
  ) u_pre (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .cmd_i   (cmd_i),
    .ctl_o   (ctl_s[0]),
    .vec_o   (vec_s[0])
  );

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
    pcc_stage #(
      .SHIFT (i)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl_s[i]),
      .vec_i  (vec_s[i]),
      .ctl_o  (ctl_s[i+1]),
      .vec_o  (vec_s[i+1])
    );
  end

  pcc_post #(
    .STEPS (CORDIC_STEPS)
  ) u_post (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_s[CORDIC_STEPS]),
    .vec_i  (vec_s[CORDIC_STEPS]),
    .done_o (done_o),
    .res_o  (result_o)
  );

  `PCC_ASSERT_IMPL(a_done_latency, clk_i, rst_ni, done_o, $past(start_i && !busy_o, LAT), "result without a transaction taken at the pipeline latency")

endmodule

// File: src/pcc_pre.sv
// Front end: range check, axis cases, angle fold, gain prescale, start vector.
module pcc_pre #(
  parameter int unsigned STEPS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  pcc_pkg::pcc_in_t   cmd_i,
  output pcc_pkg::pcc_ctl_t  ctl_o,
  output pcc_pkg::pcc_vec_t  vec_o
);

  localparam logic [pcc_pkg::K_W-1:0] GAIN = pcc_pkg::gain_q30(STEPS);
  localparam int unsigned VW = pcc_pkg::VEC_W;
  localparam int unsigned GD = pcc_pkg::GUARD;

  logic signed [31:0] a, b, zf;
  logic signed [32:0] xs, ys, xa, ya, m, mag33;
  logic               is_c2p, err, axis, neg;
  pcc_pkg::pcc_out_t  fr;
  logic [60:0]        prod_d;

  pcc_pkg::pcc_ctl_t       ctl1_d, ctl1_q;
  logic [60:0]             prod_q;
  logic                    neg1_q;
  logic signed [31:0]      z1_q;
  logic signed [VW-1:0]    xv1_d, yv1_d, xv1_q, yv1_q;

  logic [61:0]             rnd;
  logic [30:0]             xr;
  logic signed [VW-1:0]    x0;
  pcc_pkg::pcc_vec_t       vec2_d, vec2_q;
  pcc_pkg::pcc_ctl_t       ctl2_q;

  // stage 1
  always_comb begin
    a      = cmd_i.coord_a;
    b      = cmd_i.coord_b;
    is_c2p = (cmd_i.op == pcc_pkg::OP_C2P);
    err    = !is_c2p && (a < 0 || b < 0 || b > pcc_pkg::ANG_2PI);

    // fold theta into [-pi/2, pi/2]; removing pi negates the start vector
    zf  = b;
    neg = 1'b0;
    if (zf > pcc_pkg::ANG_PI) zf = zf - pcc_pkg::ANG_2PI;
    if (zf > pcc_pkg::ANG_HALF_PI) begin
      zf  = zf - pcc_pkg::ANG_PI;
      neg = 1'b1;
    end else if (zf < -pcc_pkg::ANG_HALF_PI) begin
      zf  = zf + pcc_pkg::ANG_PI;
      neg = 1'b1;
    end

    // vectoring start: mirror into the right half plane
    xs = {a[31], a};
    ys = {b[31], b};
    xa = a[31] ? -xs : xs;
    ya = a[31] ? -ys : ys;
    xv1_d = {{(VW-33-GD){xa[32]}}, xa, {GD{1'b0}}};
    yv1_d = {{(VW-33-GD){ya[32]}}, ya, {GD{1'b0}}};

    // on an axis the answer is exact
    axis  = is_c2p && (a == 0 || b == 0);
    m     = (a == 0) ? ys : xs;
    mag33 = m[32] ? -m : m;
    if (err) begin
      fr.result_a    = '0;
      fr.result_b    = '0;
      fr.range_error = 1'b1;
    end else begin
      fr.result_a    = mag33[31] ? pcc_pkg::LEN_MAX : mag33[31:0];
      if (a == 0) fr.result_b = b[31] ? pcc_pkg::ANG_3HALF_PI : pcc_pkg::ANG_HALF_PI;
      else        fr.result_b = a[31] ? pcc_pkg::ANG_PI : '0;
      fr.range_error = 1'b0;
    end

    ctl1_d.vld     = start_i;
    ctl1_d.op      = cmd_i.op;
    ctl1_d.frc     = err || axis;
    ctl1_d.frc_res = fr;
    ctl1_d.xneg    = a[31];
    ctl1_d.yneg    = b[31];

    prod_d = 61'(a[30:0]) * 61'(GAIN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
    end else begin
      ctl1_q <= ctl1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    neg1_q <= neg;
    z1_q   <= zf;
    xv1_q  <= xv1_d;
    yv1_q  <= yv1_d;
  end

  // stage 2: round the prescaled radius and place it above the guard bits
  always_comb begin
    rnd = 62'(prod_q) + (62'd1 << 29);
    xr  = rnd[60:30];
    x0  = {{(VW-31-GD){1'b0}}, xr, {GD{1'b0}}};
    if (ctl1_q.op == pcc_pkg::OP_P2C) begin
      vec2_d.x = neg1_q ? -x0 : x0;
      vec2_d.y = '0;
      vec2_d.z = z1_q;
    end else begin
      vec2_d.x = xv1_q;
      vec2_d.y = yv1_q;
      vec2_d.z = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl2_q <= '0;
    end else begin
      ctl2_q <= ctl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    vec2_q <= vec2_d;
  end

  assign ctl_o = ctl2_q;
  assign vec_o = vec2_q;

endmodule

// File: src/pcc_stage.sv
// One registered CORDIC micro-rotation, rotation or vectoring by op.
module pcc_stage #(
  parameter int unsigned SHIFT = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pcc_pkg::pcc_ctl_t ctl_i,
  input  pcc_pkg::pcc_vec_t vec_i,
  output pcc_pkg::pcc_ctl_t ctl_o,
  output pcc_pkg::pcc_vec_t vec_o
);

  localparam logic signed [31:0] ATAN = pcc_pkg::atan_lut(SHIFT);

  logic signed [pcc_pkg::VEC_W-1:0] x, y, dx, dy;
  logic signed [pcc_pkg::ANG_W-1:0] z;
  logic                             plus;
  pcc_pkg::pcc_vec_t                vec_d, vec_q;
  pcc_pkg::pcc_ctl_t                ctl_q;

  always_comb begin
    x  = vec_i.x;
    y  = vec_i.y;
    z  = vec_i.z;
    dx = y >>> SHIFT;
    dy = x >>> SHIFT;
    // rotation drives z to zero, vectoring drives y to zero
    plus = (ctl_i.op == pcc_pkg::OP_P2C) ? !z[pcc_pkg::ANG_W-1]
                                        : y[pcc_pkg::VEC_W-1];
    if (plus) begin
      vec_d.x = x - dx;
      vec_d.y = y + dy;
      vec_d.z = z - ATAN;
    end else begin
      vec_d.x = x + dx;
      vec_d.y = y - dy;
      vec_d.z = z + ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    vec_q <= vec_d;
  end

  assign ctl_o = ctl_q;
  assign vec_o = vec_q;

endmodule

// File: src/pcc_post.sv
// Back end: rounding, gain correction of r, quadrant fix of theta, output register.
`include "polar_cartesian_converter_defines.svh"

module pcc_post #(
  parameter int unsigned STEPS = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pcc_pkg::pcc_ctl_t ctl_i,
  input  pcc_pkg::pcc_vec_t vec_i,
  output logic              done_o,
  output pcc_pkg::pcc_out_t res_o
);

  localparam int unsigned KW   = pcc_pkg::K_W;
  localparam int unsigned GD   = pcc_pkg::GUARD;
  localparam int unsigned VW   = pcc_pkg::VEC_W;
  localparam int unsigned UX_W = VW - 1;
  localparam int unsigned HI_W = UX_W - GD + KW;
  localparam int unsigned LO_W = GD + KW;
  localparam int unsigned SW   = VW - GD;
  localparam logic [KW-1:0] GAIN = pcc_pkg::gain_q30(STEPS);

  logic signed [VW-1:0]  x, y, xr, yr;
  logic signed [SW-1:0]  xs, ys;
  logic [UX_W-1:0]       ux;
  logic signed [32:0]    zs, th_d;
  logic [31:0]           cx_d, cy_d;
  logic [HI_W-1:0]       hi_d;
  logic [LO_W-1:0]       lo_d;

  pcc_pkg::pcc_ctl_t     ctla_q;
  logic [31:0]           cx_q, cy_q;
  logic [HI_W-1:0]       hi_q;
  logic [LO_W-1:0]       lo_q;
  logic signed [32:0]    th_q;

  logic [HI_W:0]         p, pr;
  logic [HI_W-30:0]      r_w;
  logic [31:0]           r_sat;
  logic signed [32:0]    lo_b, hi_b, th_c;
  pcc_pkg::pcc_out_t     res_d, res_q;
  logic                  done_q;
  pcc_pkg::pcc_op_e      op_q;

  // stage A
  always_comb begin
    x  = vec_i.x;
    y  = vec_i.y;
    xr = x + (VW'(1) <<< (GD - 1));
    yr = y + (VW'(1) <<< (GD - 1));
    xs = xr[VW-1:GD];
    ys = yr[VW-1:GD];
    // saturate the rounded rotation outputs to 32 bits
    if (xs[SW-1:31] != {(SW-31){xs[SW-1]}}) cx_d = xs[SW-1] ? 32'h8000_0000 : 32'h7fff_ffff;
    else                                     cx_d = xs[31:0];
    if (ys[SW-1:31] != {(SW-31){ys[SW-1]}}) cy_d = ys[SW-1] ? 32'h8000_0000 : 32'h7fff_ffff;
    else                                     cy_d = ys[31:0];

    ux   = x[VW-1] ? '0 : x[UX_W-1:0];
    hi_d = HI_W'(ux[UX_W-1:GD]) * HI_W'(GAIN);
    lo_d = LO_W'(ux[GD-1:0]) * LO_W'(GAIN);

    zs = {vec_i.z[31], vec_i.z};
    if (ctl_i.xneg)  th_d = zs + {1'b0, pcc_pkg::ANG_PI};
    else if (zs < 0) th_d = zs + {1'b0, pcc_pkg::ANG_2PI};
    else             th_d = zs;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctla_q <= '0;
    end else begin
      ctla_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q <= cx_d;
    cy_q <= cy_d;
    hi_q <= hi_d;
    lo_q <= lo_d;
    th_q <= th_d;
  end

  // stage B
  always_comb begin
    p     = (HI_W+1)'(hi_q) + (HI_W+1)'(lo_q[LO_W-1:GD]);
    pr    = p + ((HI_W+1)'(1) << 29);
    r_w   = pr[HI_W:30];
    r_sat = (|r_w[HI_W-30:31]) ? 32'h7fff_ffff : r_w[31:0];

    // keep theta inside the quadrant given by the input signs
    if (!ctla_q.xneg && !ctla_q.yneg) begin
      lo_b = '0;
      hi_b = {1'b0, pcc_pkg::ANG_HALF_PI};
    end else if (ctla_q.xneg && !ctla_q.yneg) begin
      lo_b = {1'b0, pcc_pkg::ANG_HALF_PI};
      hi_b = {1'b0, pcc_pkg::ANG_PI};
    end else if (ctla_q.xneg) begin
      lo_b = {1'b0, pcc_pkg::ANG_PI};
      hi_b = {1'b0, pcc_pkg::ANG_3HALF_PI};
    end else begin
      lo_b = {1'b0, pcc_pkg::ANG_3HALF_PI};
      hi_b = {1'b0, pcc_pkg::ANG_2PI_M1};
    end
    th_c = th_q;
    if (th_c < lo_b) th_c = lo_b;
    if (th_c > hi_b) th_c = hi_b;

    if (ctla_q.frc) begin
      res_d = ctla_q.frc_res;
    end else if (ctla_q.op == pcc_pkg::OP_P2C) begin
      res_d.result_a    = cx_q;
      res_d.result_b    = cy_q;
      res_d.range_error = 1'b0;
    end else begin
      res_d.result_a    = r_sat;
      res_d.result_b    = th_c[31:0];
      res_d.range_error = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctla_q.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    op_q  <= ctla_q.op;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  `PCC_ASSERT_IMPL(a_polar_out_range, clk_i, rst_ni, done_q && op_q == pcc_pkg::OP_C2P, !res_q.result_a[31] && !res_q.result_b[31] && res_q.result_b < pcc_pkg::ANG_2PI, "cartesian to polar result out of range")
  `PCC_ASSERT_IMPL(a_err_zero, clk_i, rst_ni, done_q && res_q.range_error, op_q == pcc_pkg::OP_P2C && res_q.result_a == 0 && res_q.result_b == 0, "range error with non-zero result")
  `PCC_ASSERT_NEXT(a_err_forced, clk_i, rst_ni, ctla_q.vld && ctla_q.frc && ctla_q.frc_res.range_error, done_q && res_q.range_error, "range error transaction lost its flag")

endmodule
